FILE: hw/rtl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared constants and codes for the pixel column to printer band converter.
// ----------------------------------------------------------------------------
package pcb_pkg;

	localparam int PRINT_SLOTS = 480;
	localparam int SLOT_W      = $clog2(PRINT_SLOTS);
	localparam int ROW_W       = 10;
	localparam int PROD_W      = ROW_W + SLOT_W;
	localparam int LEN_BAND    = PRINT_SLOTS + 6;
	localparam int LEN_START   = 6;
	localparam int LEN_FINISH  = 1;
	localparam int POS_W       = $clog2(LEN_BAND);
	localparam int DCNT_W      = $clog2(PROD_W + 1);
	localparam int ENTRY_W     = 9;   // touched mark over slot byte

	// request codes
	localparam logic [1:0] REQ_PIXEL  = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	// register indexes
	localparam logic [1:0] REG_PRINT_ENABLE = 2'd0;
	localparam logic [1:0] REG_COLOR_MASK   = 2'd1;
	localparam logic [1:0] REG_LINE_SPACING = 2'd2;
	localparam logic [1:0] REG_LAST_ROW     = 2'd3;

	// printer bytes
	localparam logic [7:0] CH_ESC  = 8'd27;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_MODE = 8'd5;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_N1   = 8'(PRINT_SLOTS % 256);
	localparam logic [7:0] CH_N2   = 8'(PRINT_SLOTS / 256);

	typedef enum logic [1:0] {
		KIND_START,
		KIND_FINISH,
		KIND_BAND
	} stream_kind_t;

endpackage

FILE: hw/rtl/pcb_if.sv
// ----------------------------------------------------------------------------
// pcb interfaces
// Valid/ready channels for requests, printer beats and register writes.
// ----------------------------------------------------------------------------
interface pcb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [3:0] pixel_color;
	logic [9:0] row;
	modport source (output valid, req_type, pixel_color, row, input ready);
	modport sink   (input valid, req_type, pixel_color, row, output ready);
endinterface

interface pcb_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last;
	modport source (output valid, out_bytes, byte_count, last, input ready);
	modport sink   (input valid, out_bytes, byte_count, last, output ready);
endinterface

interface pcb_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/pcb_ram.sv
// ----------------------------------------------------------------------------
// pcb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/pixel_column_to_printer_bands_top.sv
// ----------------------------------------------------------------------------
// pixel_column_to_printer_bands_top
// Screen dump to an 8-pin printer in bit-image mode, one pixel per request.
// ----------------------------------------------------------------------------
// Pixels arrive column by column; each is accepted in the idle state, which
// forms row*(slots-1), then runs through the restoring divider at one
// quotient bit per cycle (19 bits), then a read-modify-write of the slot RAM.
// The block takes one request at a time and drops ready while busy. At the
// end of the eighth column the gap fill walks the slot RAM, reading and
// writing back each slot in turn; then, with printing on, the band goes out
// as 61 beats, the bytes of each beat gathered one by one (slot bytes read
// from the RAM) and each beat held until its handshake, and a clearing pass
// empties the store. Start and finish requests emit one beat and run the same
// clearing pass. After reset the block runs a clearing pass before it accepts
// a request; register writes are taken at any time. Bytes sit first in the
// lowest byte of out_bytes and last marks the final beat of each stream.
// ----------------------------------------------------------------------------
module pixel_column_to_printer_bands_top (
	input  logic clk,
	input  logic arst_n,
	pcb_in_if.sink    pix_in,
	pcb_out_if.source band_out,
	pcb_cfg_if.sink   cfg
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DIV, ST_PXRD, ST_PXWR,
		ST_GF0, ST_GF1, ST_GF2, ST_GFRD, ST_GFWR,
		ST_EMRD, ST_EMACC, ST_OUT
	} state_t;

	state_t                       state_q;
	logic                         en_q;
	logic [15:0]                  mask_q;
	logic [7:0]                   spacing_q;
	logic [9:0]                   last_row_q;
	logic [3:0]                   color_q;
	logic [9:0]                   row_q;
	logic [2:0]                   col_q;
	logic [pcb_pkg::PROD_W-1:0]   quo_q;
	logic [9:0]                   rem_q;
	logic [pcb_pkg::DCNT_W-1:0]   dcnt_q;
	logic [pcb_pkg::SLOT_W-1:0]   idx_q;
	logic [7:0]                   prev_q;
	logic [pcb_pkg::ENTRY_W-1:0]  cur_q;
	pcb_pkg::stream_kind_t        kind_q;
	logic [pcb_pkg::POS_W-1:0]    pos_q;
	logic [63:0]                  word_q;
	logic [3:0]                   cnt_q;
	logic                         last_q;

	// ram port
	logic                         ram_we;
	logic [pcb_pkg::SLOT_W-1:0]   ram_waddr, ram_raddr;
	logic [pcb_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

	pcb_ram #(.WIDTH(pcb_pkg::ENTRY_W), .DEPTH(pcb_pkg::PRINT_SLOTS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// divider step
	logic [9:0]  divisor;
	logic [10:0] trial;
	logic        fits;
	assign divisor = (last_row_q == 10'd0) ? 10'd1 : last_row_q;
	assign trial   = {rem_q, quo_q[pcb_pkg::PROD_W-1]};
	assign fits    = trial >= {1'b0, divisor};

	// slot from quotient, saturated to the last slot
	logic [pcb_pkg::SLOT_W-1:0] slot;
	assign slot = (quo_q > pcb_pkg::PROD_W'(pcb_pkg::PRINT_SLOTS - 1)) ?
		pcb_pkg::SLOT_W'(pcb_pkg::PRINT_SLOTS - 1) : quo_q[pcb_pkg::SLOT_W-1:0];

	logic [7:0] dot;
	assign dot = (en_q && mask_q[color_q]) ? (8'h80 >> col_q) : 8'h00;

	// gap fill of the current slot
	logic [7:0] filled;
	assign filled = cur_q[8] ? cur_q[7:0] : (cur_q[7:0] | (prev_q & ram_rdata[7:0]));

	// stream byte at pos_q
	logic [pcb_pkg::POS_W-1:0] len_m1;
	logic [7:0]                sbyte;
	logic [2:0]                lane;
	logic                      at_end;
	assign lane = pos_q[2:0];

	always_comb begin
		sbyte  = pcb_pkg::CH_LF;
		len_m1 = pcb_pkg::POS_W'(pcb_pkg::LEN_BAND - 1);
		unique case (kind_q)
			pcb_pkg::KIND_START: begin
				len_m1 = pcb_pkg::POS_W'(pcb_pkg::LEN_START - 1);
				if (pos_q == pcb_pkg::POS_W'(0)) sbyte = pcb_pkg::CH_ESC;
				else if (pos_q == pcb_pkg::POS_W'(1)) sbyte = pcb_pkg::CH_THREE;
				else if (pos_q == pcb_pkg::POS_W'(2)) sbyte = spacing_q;
			end
			pcb_pkg::KIND_FINISH: begin
				len_m1 = pcb_pkg::POS_W'(pcb_pkg::LEN_FINISH - 1);
			end
			default: begin
				if (pos_q == pcb_pkg::POS_W'(0)) sbyte = pcb_pkg::CH_ESC;
				else if (pos_q == pcb_pkg::POS_W'(1)) sbyte = pcb_pkg::CH_STAR;
				else if (pos_q == pcb_pkg::POS_W'(2)) sbyte = pcb_pkg::CH_MODE;
				else if (pos_q == pcb_pkg::POS_W'(3)) sbyte = pcb_pkg::CH_N1;
				else if (pos_q == pcb_pkg::POS_W'(4)) sbyte = pcb_pkg::CH_N2;
				else if (pos_q != pcb_pkg::POS_W'(pcb_pkg::LEN_BAND - 1))
					sbyte = ram_rdata[7:0];
			end
		endcase
	end
	assign at_end = pos_q == len_m1;

	// ram control per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = cur_q;
		ram_raddr = idx_q;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_PXRD: ram_raddr = slot;
			ST_PXWR: begin
				ram_we    = 1'b1;
				ram_waddr = slot;
				ram_wdata = {1'b1, ram_rdata[7:0] | dot};
			end
			ST_GF0:  ram_raddr = '0;
			ST_GF1:  ram_raddr = pcb_pkg::SLOT_W'(1);
			ST_GFRD: ram_raddr = idx_q + pcb_pkg::SLOT_W'(1);
			ST_GFWR: begin
				ram_we    = 1'b1;
				ram_wdata = {cur_q[8], filled};
			end
			ST_EMRD: ram_raddr = pcb_pkg::SLOT_W'(pos_q - pcb_pkg::POS_W'(5));
			default: ;
		endcase
	end

	assign pix_in.ready        = state_q == ST_IDLE;
	assign cfg.ready           = 1'b1;
	assign band_out.valid      = state_q == ST_OUT;
	assign band_out.out_bytes  = word_q;
	assign band_out.byte_count = cnt_q;
	assign band_out.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			en_q       <= 1'b0;
			mask_q     <= 16'hFFFE;
			spacing_q  <= 8'd24;
			last_row_q <= 10'd479;
			color_q    <= '0;
			row_q      <= '0;
			col_q      <= '0;
			quo_q      <= '0;
			rem_q      <= '0;
			dcnt_q     <= '0;
			idx_q      <= '0;
			prev_q     <= '0;
			cur_q      <= '0;
			kind_q     <= pcb_pkg::KIND_FINISH;
			pos_q      <= '0;
			word_q     <= '0;
			cnt_q      <= 4'd1;
			last_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					pcb_pkg::REG_PRINT_ENABLE: en_q       <= cfg.data[0];
					pcb_pkg::REG_COLOR_MASK:   mask_q     <= cfg.data;
					pcb_pkg::REG_LINE_SPACING: spacing_q  <= cfg.data[7:0];
					pcb_pkg::REG_LAST_ROW:     last_row_q <= cfg.data[9:0];
				endcase
			end
			unique case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + pcb_pkg::SLOT_W'(1);
					if (idx_q == pcb_pkg::SLOT_W'(pcb_pkg::PRINT_SLOTS - 1)) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pix_in.valid) begin
						color_q <= pix_in.pixel_color;
						row_q   <= pix_in.row;
						quo_q   <= pcb_pkg::PROD_W'(pix_in.row) *
							pcb_pkg::PROD_W'(pcb_pkg::PRINT_SLOTS - 1);
						rem_q   <= '0;
						dcnt_q  <= '0;
						pos_q   <= '0;
						unique case (pix_in.req_type)
							pcb_pkg::REQ_PIXEL: state_q <= ST_DIV;
							pcb_pkg::REQ_START: begin
								col_q   <= '0;
								kind_q  <= pcb_pkg::KIND_START;
								state_q <= ST_EMRD;
							end
							pcb_pkg::REQ_FINISH: begin
								col_q   <= '0;
								kind_q  <= pcb_pkg::KIND_FINISH;
								state_q <= ST_EMRD;
							end
							default: ;  // unused code, no effect
						endcase
					end
				end
				ST_DIV: begin
					quo_q  <= {quo_q[pcb_pkg::PROD_W-2:0], fits};
					rem_q  <= fits ? 10'(trial - {1'b0, divisor}) : trial[9:0];
					dcnt_q <= dcnt_q + pcb_pkg::DCNT_W'(1);
					if (dcnt_q == pcb_pkg::DCNT_W'(pcb_pkg::PROD_W - 1)) state_q <= ST_PXRD;
				end
				ST_PXRD: state_q <= ST_PXWR;
				ST_PXWR: begin
					if (row_q != last_row_q) begin
						state_q <= ST_IDLE;
					end else if (col_q == 3'd7) begin
						col_q   <= '0;
						state_q <= ST_GF0;
					end else begin
						col_q   <= col_q + 3'd1;
						state_q <= ST_IDLE;
					end
				end
				ST_GF0: state_q <= ST_GF1;
				ST_GF1: begin
					prev_q  <= ram_rdata[7:0];
					state_q <= ST_GF2;
				end
				ST_GF2: begin
					cur_q   <= ram_rdata;
					idx_q   <= pcb_pkg::SLOT_W'(1);
					state_q <= ST_GFRD;
				end
				ST_GFRD: state_q <= ST_GFWR;
				ST_GFWR: begin
					prev_q <= filled;
					cur_q  <= ram_rdata;
					idx_q  <= idx_q + pcb_pkg::SLOT_W'(1);
					state_q <= ST_GFRD;
					if (idx_q == pcb_pkg::SLOT_W'(pcb_pkg::PRINT_SLOTS - 2)) begin
						idx_q   <= '0;
						kind_q  <= pcb_pkg::KIND_BAND;
						pos_q   <= '0;
						state_q <= en_q ? ST_EMRD : ST_IDLE;
					end
				end
				ST_EMRD: state_q <= ST_EMACC;
				ST_EMACC: begin
					word_q <= (lane == 3'd0) ? 64'(sbyte) :
						(word_q | (64'(sbyte) << {lane, 3'b000}));
					cnt_q  <= {1'b0, lane} + 4'd1;
					last_q <= at_end;
					pos_q  <= pos_q + pcb_pkg::POS_W'(1);
					state_q <= (lane == 3'd7 || at_end) ? ST_OUT : ST_EMRD;
				end
				ST_OUT: begin
					if (band_out.ready) begin
						state_q <= last_q ? ST_CLR : ST_EMRD;
						idx_q   <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// beats carry one to eight bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		band_out.valid |-> (band_out.byte_count != 4'd0 && band_out.byte_count <= 4'd8))
		else $error("byte count out of range");

	// a request is never taken while a beat is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_in.ready && band_out.valid))
		else $error("ready while beat pending");

	// a short beat only ends a stream
	assert property (@(posedge clk) disable iff (!arst_n)
		(band_out.valid && band_out.byte_count != 4'd8) |-> band_out.last)
		else $error("short beat inside stream");

	// after the final beat is taken the store is cleared before the next request
	assert property (@(posedge clk) disable iff (!arst_n)
		(band_out.valid && band_out.ready && band_out.last) |=> !pix_in.ready)
		else $error("clear pass skipped");

endmodule
